[rtl/vei_pkg.sv]
package vei_pkg;

  localparam int unsigned VERTEX_BITS  = 12;
  localparam int unsigned ELEM_BITS    = 16;
  localparam int unsigned MAX_DEGREE   = 16;
  localparam int unsigned SLOT_BITS    = 4;
  localparam int unsigned LEN_BITS     = 5;
  localparam int unsigned CFG_BITS     = 13;
  localparam logic [CFG_BITS-1:0] CFG_RESET = 13'd4096;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_CLR,
    S_EMIT,
    S_A_LEN,
    S_A_CMP,
    S_A_PUT,
    S_Q_LEN,
    S_Q_CPY,
    S_Q_MRG,
    S_Q_OUT
  } state_t;

endpackage

[rtl/vertex_element_incidence_table_top.sv]
// Vertex-to-element incidence table. Each vertex owns 16 slots in a 64K x 16
// element memory plus a length entry in a 4K x 5 memory; add requests insert
// an element in sorted order, query requests intersect the named lists and the
// last request of a run streams the survivors, one result per cycle while the
// output is not stalled. After reset and on every clear request the block makes
// a pass over the length memory, during which no request is taken. An add
// compares stored slots one at a time while finding its place, and a query
// step copies or merges one slot at a time, as the element memory has a single
// read port.
module vertex_element_incidence_table_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // element[15:0], vertex[27:16], zero[31:28]
  input  logic [2:0]  in_tuser,   // mode[1:0], absent[2]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // found_element[15:0]
  output logic [2:0]  out_tuser,  // found[0], status[2:1]
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_data
);

  localparam int unsigned VB = vei_pkg::VERTEX_BITS;
  localparam int unsigned EB = vei_pkg::ELEM_BITS;
  localparam int unsigned SB = vei_pkg::SLOT_BITS;
  localparam int unsigned LB = vei_pkg::LEN_BITS;

  logic [EB-1:0] st_mem [0:(1<<(VB+SB))-1];
  logic [LB-1:0] ln_mem [0:(1<<VB)-1];
  logic [EB-1:0] cand_r [0:vei_pkg::MAX_DEGREE-1];

  vei_pkg::state_t state_r, state_nxt;
  logic [1:0]    mode_r, mode_nxt;
  logic [EB-1:0] elem_r, elem_nxt;
  logic [VB-1:0] vtx_r, vtx_nxt;
  logic          abs_r, abs_nxt, last_r, last_nxt;
  logic [12:0]   cfg_r;
  logic [LB-1:0] len_r, len_nxt, n_r, n_nxt, j_r, j_nxt, i_r, i_nxt;
  logic [LB-1:0] kept_r, kept_nxt, k_r, k_nxt, cnt_r, cnt_nxt;
  logic          qopen_r, qopen_nxt, rflag_r, rflag_nxt, first_r, first_nxt;
  logic [1:0]    res_st_r, res_st_nxt;
  logic [VB-1:0] clr_r, clr_nxt;
  logic          clr_emit_r, clr_emit_nxt;
  logic          out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic          out_found_r, out_found_nxt;
  logic [1:0]    out_st_r, out_st_nxt;
  logic [EB-1:0] out_elem_r, out_elem_nxt;

  logic          st_we, st_re, ln_we, ln_re, cand_we;
  logic [SB-1:0] st_wslot, st_rslot, cand_wa, cand_ra;
  logic [EB-1:0] st_wd, st_rd_r, cand_wd, a_val, b_val;
  logic [LB-1:0] ln_wd, ln_rd_r;
  logic [VB-1:0] ln_wa;

  logic in_acc, out_free, in_range, a_ge_b, b_ge_a, m_brk;
  logic [LB-1:0] j_inc, i_inc, k_inc, n_dec, kept_inc;

  assign in_tready  = (state_r == vei_pkg::S_IDLE);
  assign cfg_ready  = 1'b1;
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign in_range   = {1'b0, vtx_r} < cfg_r;
  assign cand_ra    = (state_r == vei_pkg::S_Q_OUT) ? k_r[SB-1:0] : i_r[SB-1:0];
  assign a_val      = cand_r[cand_ra];
  assign b_val      = st_rd_r;
  assign a_ge_b     = a_val >= b_val;
  assign b_ge_a     = b_val >= a_val;
  assign j_inc      = j_r + LB'(1);
  assign i_inc      = i_r + LB'(1);
  assign k_inc      = k_r + LB'(1);
  assign n_dec      = n_r - LB'(1);
  assign kept_inc   = kept_r + LB'(1);
  assign m_brk      = (a_ge_b && j_inc == len_r) || (b_ge_a && i_inc == cnt_r);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_elem_r;
  assign out_tuser  = {out_st_r, out_found_r};
  assign out_tlast  = out_last_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vei_pkg::S_IDLE: if (in_acc) state_nxt = vei_pkg::S_DISP;
      vei_pkg::S_DISP: begin
        case (mode_r)
          vei_pkg::MODE_CLEAR: state_nxt = vei_pkg::S_CLR;
          vei_pkg::MODE_ADD: begin
            if (abs_r || !in_range) state_nxt = vei_pkg::S_EMIT;
            else state_nxt = vei_pkg::S_A_LEN;
          end
          vei_pkg::MODE_QUERY: begin
            if (!abs_r && in_range && (!qopen_r || cnt_r != '0))
              state_nxt = vei_pkg::S_Q_LEN;
            else state_nxt = last_r ? vei_pkg::S_Q_OUT : vei_pkg::S_IDLE;
          end
          default: state_nxt = vei_pkg::S_IDLE;
        endcase
      end
      vei_pkg::S_CLR: begin
        if (&clr_r) state_nxt = clr_emit_r ? vei_pkg::S_EMIT : vei_pkg::S_IDLE;
      end
      vei_pkg::S_EMIT: if (out_free) state_nxt = vei_pkg::S_IDLE;
      vei_pkg::S_A_LEN: begin
        if (ln_rd_r[LB-1]) state_nxt = vei_pkg::S_EMIT;
        else if (ln_rd_r == '0) state_nxt = vei_pkg::S_A_PUT;
        else state_nxt = vei_pkg::S_A_CMP;
      end
      vei_pkg::S_A_CMP: begin
        if (!(b_val > elem_r) || n_dec == '0) state_nxt = vei_pkg::S_A_PUT;
      end
      vei_pkg::S_A_PUT: state_nxt = vei_pkg::S_EMIT;
      vei_pkg::S_Q_LEN: begin
        if (ln_rd_r == '0) state_nxt = last_r ? vei_pkg::S_Q_OUT : vei_pkg::S_IDLE;
        else state_nxt = first_r ? vei_pkg::S_Q_CPY : vei_pkg::S_Q_MRG;
      end
      vei_pkg::S_Q_CPY: begin
        if (j_inc == len_r) state_nxt = last_r ? vei_pkg::S_Q_OUT : vei_pkg::S_IDLE;
      end
      vei_pkg::S_Q_MRG: begin
        if (m_brk) state_nxt = last_r ? vei_pkg::S_Q_OUT : vei_pkg::S_IDLE;
      end
      vei_pkg::S_Q_OUT: begin
        if (out_free && (!(qopen_r && cnt_r != '0) || k_inc == cnt_r))
          state_nxt = vei_pkg::S_IDLE;
      end
      default: state_nxt = vei_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    mode_nxt = mode_r; elem_nxt = elem_r; vtx_nxt = vtx_r;
    abs_nxt = abs_r; last_nxt = last_r;
    len_nxt = len_r; n_nxt = n_r; j_nxt = j_r; i_nxt = i_r;
    kept_nxt = kept_r; k_nxt = k_r; cnt_nxt = cnt_r;
    qopen_nxt = qopen_r; rflag_nxt = rflag_r; first_nxt = first_r;
    res_st_nxt = res_st_r; clr_nxt = clr_r; clr_emit_nxt = clr_emit_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_elem_nxt = out_elem_r; out_found_nxt = out_found_r;
    out_st_nxt = out_st_r; out_last_nxt = out_last_r;
    st_we = 1'b0; st_wslot = n_r[SB-1:0]; st_wd = elem_r;
    st_re = 1'b0; st_rslot = '0;
    ln_we = 1'b0; ln_wa = vtx_r; ln_wd = len_r + LB'(1); ln_re = 1'b0;
    cand_we = 1'b0; cand_wa = j_r[SB-1:0]; cand_wd = st_rd_r;
    case (state_r)
      vei_pkg::S_IDLE: begin
        if (in_acc) begin
          mode_nxt = in_tuser[1:0];
          abs_nxt  = in_tuser[2];
          elem_nxt = in_tdata[EB-1:0];
          vtx_nxt  = in_tdata[16 +: VB];
          last_nxt = in_tlast;
        end
      end
      vei_pkg::S_DISP: begin
        k_nxt = '0;
        res_st_nxt = vei_pkg::ST_OK;
        case (mode_r)
          vei_pkg::MODE_CLEAR: begin
            clr_nxt = '0; clr_emit_nxt = 1'b1;
            cnt_nxt = '0; qopen_nxt = 1'b0; rflag_nxt = 1'b0;
          end
          vei_pkg::MODE_ADD: begin
            if (!abs_r && !in_range) res_st_nxt = vei_pkg::ST_RANGE;
            ln_re = !abs_r && in_range;
          end
          vei_pkg::MODE_QUERY: begin
            if (!abs_r) begin
              if (!in_range) rflag_nxt = 1'b1;
              first_nxt = !qopen_r;
              if (!qopen_r) begin
                qopen_nxt = 1'b1;
                cnt_nxt = '0;
              end else if (!in_range) begin
                cnt_nxt = '0;
              end
              ln_re = in_range && (!qopen_r || cnt_r != '0);
            end
          end
          default: ;
        endcase
      end
      vei_pkg::S_CLR: begin
        ln_we = 1'b1; ln_wa = clr_r; ln_wd = '0;
        clr_nxt = clr_r + VB'(1);
      end
      vei_pkg::S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1; out_elem_nxt = '0; out_found_nxt = 1'b0;
          out_st_nxt = res_st_r; out_last_nxt = 1'b1;
          clr_emit_nxt = 1'b0;
        end
      end
      vei_pkg::S_A_LEN: begin
        len_nxt = ln_rd_r;
        n_nxt = ln_rd_r;
        if (ln_rd_r[LB-1]) res_st_nxt = vei_pkg::ST_FULL;
        st_re = !ln_rd_r[LB-1] && ln_rd_r != '0;
        st_rslot = SB'(ln_rd_r - LB'(1));
      end
      vei_pkg::S_A_CMP: begin
        if (b_val > elem_r) begin
          st_we = 1'b1; st_wd = b_val;
          n_nxt = n_dec;
          st_re = n_dec != '0;
          st_rslot = SB'(n_dec - LB'(1));
        end
      end
      vei_pkg::S_A_PUT: begin
        st_we = 1'b1;
        ln_we = 1'b1;
      end
      vei_pkg::S_Q_LEN: begin
        len_nxt = ln_rd_r;
        j_nxt = '0; i_nxt = '0; kept_nxt = '0;
        if (ln_rd_r == '0) cnt_nxt = '0;
        st_re = ln_rd_r != '0;
      end
      vei_pkg::S_Q_CPY: begin
        cand_we = 1'b1;
        j_nxt = j_inc;
        if (j_inc == len_r) cnt_nxt = len_r;
        else begin
          st_re = 1'b1; st_rslot = j_inc[SB-1:0];
        end
      end
      vei_pkg::S_Q_MRG: begin
        if (a_val == b_val) begin
          cand_we = 1'b1; cand_wa = kept_r[SB-1:0]; cand_wd = a_val;
          kept_nxt = kept_inc;
        end
        if (a_ge_b) j_nxt = j_inc;
        if (b_ge_a) i_nxt = i_inc;
        if (m_brk) cnt_nxt = (a_val == b_val) ? kept_inc : kept_r;
        else if (a_ge_b) begin
          st_re = 1'b1; st_rslot = j_inc[SB-1:0];
        end
      end
      vei_pkg::S_Q_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_st_nxt = rflag_r ? vei_pkg::ST_RANGE : vei_pkg::ST_OK;
          if (qopen_r && cnt_r != '0) begin
            out_elem_nxt = a_val; out_found_nxt = 1'b1;
            out_last_nxt = k_inc == cnt_r;
            k_nxt = k_inc;
          end else begin
            out_elem_nxt = '0; out_found_nxt = 1'b0; out_last_nxt = 1'b1;
          end
          if (!(qopen_r && cnt_r != '0) || k_inc == cnt_r) begin
            qopen_nxt = 1'b0; cnt_nxt = '0; rflag_nxt = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_we) st_mem[{vtx_r, st_wslot}] <= st_wd;
    if (st_re) st_rd_r <= st_mem[{vtx_r, st_rslot}];
    if (ln_we) ln_mem[ln_wa] <= ln_wd;
    if (ln_re) ln_rd_r <= ln_mem[vtx_r];
    if (cand_we) cand_r[cand_wa] <= cand_wd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vei_pkg::S_CLR;
      cfg_r       <= vei_pkg::CFG_RESET;
      cnt_r       <= '0;
      qopen_r     <= 1'b0;
      rflag_r     <= 1'b0;
      clr_r       <= '0;
      clr_emit_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_valid && cfg_ready) cfg_r <= cfg_data;
      cnt_r       <= cnt_nxt;
      qopen_r     <= qopen_nxt;
      rflag_r     <= rflag_nxt;
      clr_r       <= clr_nxt;
      clr_emit_r  <= clr_emit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt; elem_r <= elem_nxt; vtx_r <= vtx_nxt;
    abs_r <= abs_nxt; last_r <= last_nxt;
    len_r <= len_nxt; n_r <= n_nxt; j_r <= j_nxt; i_r <= i_nxt;
    kept_r <= kept_nxt; k_r <= k_nxt; first_r <= first_nxt;
    res_st_r <= res_st_nxt;
    out_elem_r <= out_elem_nxt; out_found_r <= out_found_nxt;
    out_st_r <= out_st_nxt; out_last_r <= out_last_nxt;
  end

`ifndef SYNTHESIS
  a_accept_disp: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == vei_pkg::S_DISP)
    else $error("request not dispatched");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LB'(vei_pkg::MAX_DEGREE))
    else $error("candidate count overflow");
  a_kept_le_i: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == vei_pkg::S_Q_MRG |-> kept_r <= i_r)
    else $error("merge write ahead of read");
`endif

endmodule
